// ===== rtl/roman_numeral_encoder_assert.svh =====
// Assertion macros for the Roman numeral encoder checker.
// Each macro expects signal clk, and all but RNE_ASSERT_RST expect rst_n, in the scope where it is used.
`ifndef ROMAN_NUMERAL_ENCODER_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define RNE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define RNE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define RNE_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rne_pkg.sv =====
package rne_pkg;

  // ASCII codes of the numeral characters
  localparam logic [6:0] SYM_I = 7'h49;
  localparam logic [6:0] SYM_V = 7'h56;
  localparam logic [6:0] SYM_X = 7'h58;
  localparam logic [6:0] SYM_L = 7'h4C;
  localparam logic [6:0] SYM_C = 7'h43;
  localparam logic [6:0] SYM_D = 7'h44;
  localparam logic [6:0] SYM_M = 7'h4D;

  // Decimal place of the digit being emitted
  localparam logic [1:0] PL_UNITS = 2'd0;
  localparam logic [1:0] PL_TENS  = 2'd1;
  localparam logic [1:0] PL_HUND  = 2'd2;
  localparam logic [1:0] PL_THOU  = 2'd3;

  // Symbol selector within a place's triple
  localparam logic [1:0] SEL_ONE  = 2'd0;
  localparam logic [1:0] SEL_FIVE = 2'd1;
  localparam logic [1:0] SEL_TEN  = 2'd2;

  typedef logic [3:0] digit_t;

  // Characters in the numeral of one decimal digit
  function automatic logic [2:0] digit_len(digit_t d);
    logic [2:0] n;
    case (d)
      4'd0:    n = 3'd0;
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Symbol selector of character k within digit d
  function automatic logic [1:0] digit_pat(digit_t d, logic [1:0] k);
    logic [1:0] s;
    case (d)
      4'd4:                   s = (k == 2'd0) ? SEL_ONE : SEL_FIVE;
      4'd9:                   s = (k == 2'd0) ? SEL_ONE : SEL_TEN;
      4'd5, 4'd6, 4'd7, 4'd8: s = (k == 2'd0) ? SEL_FIVE : SEL_ONE;
      default:                s = SEL_ONE;
    endcase
    return s;
  endfunction

  // Character for a place and selector
  function automatic logic [6:0] place_sym(logic [1:0] pl, logic [1:0] sel);
    logic [6:0] c;
    case (pl)
      PL_UNITS: c = (sel == SEL_ONE) ? SYM_I : (sel == SEL_FIVE) ? SYM_V : SYM_X;
      PL_TENS:  c = (sel == SEL_ONE) ? SYM_X : (sel == SEL_FIVE) ? SYM_L : SYM_C;
      PL_HUND:  c = (sel == SEL_ONE) ? SYM_C : (sel == SEL_FIVE) ? SYM_D : SYM_M;
      default:  c = SYM_M;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/rne_in_if.sv =====
interface rne_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/rne_out_if.sv =====
interface rne_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== rtl/roman_numeral_encoder.sv =====
// Channel  Dir  Payload                    Handshake
// in_ch    in   value[11:0]                valid/ready, one request per value
// out_ch   out  symbol[6:0], last          valid/ready, one request per character
//
// One character leaves per cycle while out_ch.ready allows; a numeral has up to 15
// characters in 0..3999 and 12 in 4000..4095. A zero value produces no character
// and is dropped on entry to the emitter. The character emitter is the rate limit.
// A request passes through stages 1 to 3, the emitter and the output register.
// Reset (rst_n low, synchronous) empties every stage; no clearing pass.
// Output stalls back up through the emitter and digit stages to in_ch.ready.
module roman_numeral_encoder (
  input  logic          clk,
  input  logic          rst_n,
  rne_in_if.sink        in_ch,
  rne_out_if.source     out_ch
);

  // ---------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------
  logic        s1_v_r;
  logic [11:0] s1_val_r;
  logic        s1_take, s2_take, s3_take, e_free;

  assign s1_take     = !s1_v_r || s2_take;
  assign in_ch.ready = s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_take) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_val_r <= in_ch.value;
    end
  end

  // Split off thousands: parallel compares, one subtract
  logic [2:0]  th_nxt;
  logic [11:0] th_base;
  logic [11:0] rem1_full;
  logic [9:0]  rem1_nxt;

  always_comb begin
    if (s1_val_r >= 12'd4000) begin
      th_nxt  = 3'd4;
      th_base = 12'd4000;
    end else if (s1_val_r >= 12'd3000) begin
      th_nxt  = 3'd3;
      th_base = 12'd3000;
    end else if (s1_val_r >= 12'd2000) begin
      th_nxt  = 3'd2;
      th_base = 12'd2000;
    end else if (s1_val_r >= 12'd1000) begin
      th_nxt  = 3'd1;
      th_base = 12'd1000;
    end else begin
      th_nxt  = 3'd0;
      th_base = 12'd0;
    end
    rem1_full = s1_val_r - th_base;
    rem1_nxt  = rem1_full[9:0];
  end

  // ---------------------------------------------------------------------
  // Stage 2: thousands and remainder below 1000
  // ---------------------------------------------------------------------
  logic       s2_v_r;
  logic [2:0] s2_th_r;
  logic [9:0] s2_rem_r;

  assign s2_take = !s2_v_r || s3_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_take) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_th_r  <= th_nxt;
      s2_rem_r <= rem1_nxt;
    end
  end

  // Split off hundreds
  rne_pkg::digit_t h_nxt;
  logic [9:0]      h_base;
  logic [9:0]      rem2_full;
  logic [6:0]      rem2_nxt;

  always_comb begin
    h_nxt  = 4'd0;
    h_base = 10'd0;
    for (int d = 1; d < 10; d++) begin
      if (s2_rem_r >= 10'(d * 100)) begin
        h_nxt  = 4'(d);
        h_base = 10'(d * 100);
      end
    end
    rem2_full = s2_rem_r - h_base;
    rem2_nxt  = rem2_full[6:0];
  end

  // ---------------------------------------------------------------------
  // Stage 3: thousands, hundreds and remainder below 100
  // ---------------------------------------------------------------------
  logic            s3_v_r;
  logic [2:0]      s3_th_r;
  rne_pkg::digit_t s3_h_r;
  logic [6:0]      s3_rem_r;

  assign s3_take = !s3_v_r || e_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_take) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_take) begin
      s3_th_r  <= s2_th_r;
      s3_h_r   <= h_nxt;
      s3_rem_r <= rem2_nxt;
    end
  end

  // Split tens and units on the way into the emitter
  rne_pkg::digit_t t_ld, u_ld;
  logic [6:0]      t_base;
  logic [6:0]      rem3_full;
  logic            ld_zero;
  logic [1:0]      ld_pl;

  always_comb begin
    t_ld   = 4'd0;
    t_base = 7'd0;
    for (int d = 1; d < 10; d++) begin
      if (s3_rem_r >= 7'(d * 10)) begin
        t_ld   = 4'(d);
        t_base = 7'(d * 10);
      end
    end
    rem3_full = s3_rem_r - t_base;
    u_ld      = rem3_full[3:0];
    ld_zero   = (s3_th_r == 3'd0) && (s3_h_r == 4'd0) && (s3_rem_r == 7'd0);
    // Start at the highest nonzero place
    if (s3_th_r != 3'd0) begin
      ld_pl = rne_pkg::PL_THOU;
    end else if (s3_h_r != 4'd0) begin
      ld_pl = rne_pkg::PL_HUND;
    end else if (t_ld != 4'd0) begin
      ld_pl = rne_pkg::PL_TENS;
    end else begin
      ld_pl = rne_pkg::PL_UNITS;
    end
  end

  // ---------------------------------------------------------------------
  // Emitter: walk digits, while the output register is not stalled one character per cycle
  // ---------------------------------------------------------------------
  logic            e_v_r;
  logic [2:0]      e_th_r;
  rne_pkg::digit_t e_h_r, e_t_r, e_u_r;
  logic [1:0]      e_pl_r;
  logic [1:0]      e_k_r;

  logic            out_v_r;
  logic [6:0]      out_sym_r;
  logic            out_last_r;

  rne_pkg::digit_t cur_d;
  logic [2:0]      cur_len;
  logic [2:0]      k_ext;
  logic [6:0]      cur_sym;
  logic            digit_end;
  logic            nz_h, nz_t, nz_u, lower_any;
  logic [1:0]      next_pl;
  logic            is_last;
  logic            emit;

  always_comb begin
    case (e_pl_r)
      rne_pkg::PL_THOU: begin
        cur_d   = {1'b0, e_th_r};
        cur_len = e_th_r;
        cur_sym = rne_pkg::SYM_M;
      end
      rne_pkg::PL_HUND: begin
        cur_d   = e_h_r;
        cur_len = rne_pkg::digit_len(e_h_r);
        cur_sym = rne_pkg::place_sym(e_pl_r, rne_pkg::digit_pat(e_h_r, e_k_r));
      end
      rne_pkg::PL_TENS: begin
        cur_d   = e_t_r;
        cur_len = rne_pkg::digit_len(e_t_r);
        cur_sym = rne_pkg::place_sym(e_pl_r, rne_pkg::digit_pat(e_t_r, e_k_r));
      end
      default: begin
        cur_d   = e_u_r;
        cur_len = rne_pkg::digit_len(e_u_r);
        cur_sym = rne_pkg::place_sym(e_pl_r, rne_pkg::digit_pat(e_u_r, e_k_r));
      end
    endcase
    k_ext     = {1'b0, e_k_r} + 3'd1;
    digit_end = (k_ext == cur_len) || (cur_d == 4'd0);
    // Nonzero digits still below the current place
    nz_h      = (e_h_r != 4'd0) && (e_pl_r > rne_pkg::PL_HUND);
    nz_t      = (e_t_r != 4'd0) && (e_pl_r > rne_pkg::PL_TENS);
    nz_u      = (e_u_r != 4'd0) && (e_pl_r > rne_pkg::PL_UNITS);
    lower_any = nz_h || nz_t || nz_u;
    next_pl   = nz_h ? rne_pkg::PL_HUND : (nz_t ? rne_pkg::PL_TENS : rne_pkg::PL_UNITS);
    is_last   = digit_end && !lower_any;
  end

  // Advance when the output register is empty or being drained
  assign emit   = e_v_r && (!out_v_r || out_ch.ready);
  assign e_free = !e_v_r || (emit && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (e_free) begin
      // Drop zero values here: they produce no character
      e_v_r <= s3_v_r && !ld_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (e_free) begin
      e_th_r <= s3_th_r;
      e_h_r  <= s3_h_r;
      e_t_r  <= t_ld;
      e_u_r  <= u_ld;
      e_pl_r <= ld_pl;
      e_k_r  <= 2'd0;
    end else if (emit) begin
      if (digit_end) begin
        e_pl_r <= next_pl;
        e_k_r  <= 2'd0;
      end else begin
        e_k_r  <= e_k_r + 2'd1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sym_r  <= cur_sym;
      out_last_r <= is_last;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.symbol = out_sym_r;
  assign out_ch.last   = out_last_r;

endmodule

// ===== rtl/rne_checker.sv =====
`include "roman_numeral_encoder_assert.svh"

module rne_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_symbol,
  input logic       out_last
);

  // A stalled character holds
  `RNE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_symbol) && $stable(out_last), "stalled output request changed")

  // Only numeral characters leave the block
  `RNE_ASSERT_NOW(a_sym_legal, out_valid, out_symbol == rne_pkg::SYM_I || out_symbol == rne_pkg::SYM_V || out_symbol == rne_pkg::SYM_X || out_symbol == rne_pkg::SYM_L || out_symbol == rne_pkg::SYM_C || out_symbol == rne_pkg::SYM_D || out_symbol == rne_pkg::SYM_M, "illegal numeral character")

  // Reset empties the output register
  `RNE_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "output valid after reset")

  // No output request follows the first cycle out of reset when no input was taken in it
  `RNE_ASSERT_NEXT(a_no_early_out, $past(!rst_n) && !(in_valid && in_ready), !out_valid, "output request without input")

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_symbol (out_ch.symbol),
  .out_last   (out_ch.last)
);
